### hdl/mmu_pkg.sv
// Shared constants, codes and helper functions for the matrix multiply unit.
package mmu_pkg;

  // Largest matrix dimension held in the element stores.
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;

  // Fixed field widths of the ports.
  localparam int DIM_W  = 4;
  localparam int POS_W  = 3;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 2 * DATA_W;
  localparam int FRAC_W = 16;

  // Reset value of every dimension register.
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Command codes carried on in_operation.
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  // Dimension register indexes on the configuration port.
  typedef enum logic [1:0] {
    CFG_ROWS_A  = 2'd0,
    CFG_INNER_A = 2'd1,
    CFG_ROWS_B  = 2'd2,
    CFG_COLS_B  = 2'd3
  } cfg_idx_t;

  // Clamp a dimension register to 1..MAX_DIM and return the last index in use.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - 1'b1);
    end
    return res;
  endfunction

  // Saturate a 64-bit sum to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat_word(input logic [ACC_W-1:0] s);
    logic [DATA_W-1:0] res;
    if ((&s[ACC_W-1:DATA_W-1]) || !(|s[ACC_W-1:DATA_W-1])) begin
      res = s[DATA_W-1:0];
    end else if (s[ACC_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### hdl/matrix_multiply_unit.sv
// Matrix multiply unit: element stores for A and B and a multiply-accumulate sequencer.
// Element writes may follow each other in every cycle while busy is low.
// A product run streams one result per element of the product, in row-major order,
// and busy drops as its final result appears.
// Each store has a single read port, so a run reads one A and one B element a cycle.
// A dimension mismatch gives one result, in the cycle after start; results cannot stall.
// Synchronous reset sets the dimension registers to 8; store contents are undefined.
module matrix_multiply_unit import mmu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [2:0]               in_row,
  input  logic [2:0]               in_col,
  input  logic signed [DATA_W-1:0] in_value,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  // Result channel
  output logic                     out_valid,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] out_product,
  output logic                     out_last,
  output logic                     out_dim_error
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Position tag that travels with each multiply through the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             first;
    logic             last_k;
    logic             final_elem;
  } tag_t;

  state_t state_r;

  logic [DIM_W-1:0] rows_a_r, inner_a_r, rows_b_r, cols_b_r;
  logic [IDX_W-1:0] ra_last_r, ia_last_r, cb_last_r;
  logic [IDX_W-1:0] i_r, j_r, k_r;

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic [ACC_W-1:0]         acc_r;

  logic v1_r, v2_r;
  tag_t t1_r, t2_r;

  logic                     out_valid_r;
  logic [POS_W-1:0]         out_row_r, out_col_r;
  logic signed [DATA_W-1:0] out_product_r;
  logic                     out_last_r, out_dim_error_r;

  logic              cmd_accept;
  logic              in_range;
  logic              wr_a, wr_b;
  logic [ADDR_W-1:0] wr_addr;
  logic              issue;
  logic              k_last, j_last, i_last;
  logic              dim_mismatch;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  sum;

  // Command decode.
  assign busy       = (state_r != S_IDLE);
  assign cmd_accept = start && !busy;
  assign in_range   = (in_row < MAX_DIM) && (in_col < MAX_DIM);
  assign wr_addr    = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};
  assign wr_a       = cmd_accept && (in_operation == OP_WRITE_A) && in_range;
  assign wr_b       = cmd_accept && (in_operation == OP_WRITE_B) && in_range;

  assign dim_mismatch = (dim_last(inner_a_r) != dim_last(rows_b_r));

  // Loop position of the element pair read in this cycle.
  assign issue  = (state_r == S_RUN);
  assign k_last = (k_r == ia_last_r);
  assign j_last = (j_r == cb_last_r);
  assign i_last = (i_r == ra_last_r);

  // Floor-rounded Q16.16 term and the running sum.
  assign term = ACC_W'(prod_r >>> FRAC_W);
  assign sum  = (t2_r.first ? '0 : acc_r) + term;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r  <= DIM_RESET;
      inner_a_r <= DIM_RESET;
      rows_b_r  <= DIM_RESET;
      cols_b_r  <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_A:  rows_a_r  <= cfg_data;
        CFG_INNER_A: inner_a_r <= cfg_data;
        CFG_ROWS_B:  rows_b_r  <= cfg_data;
        CFG_COLS_B:  cols_b_r  <= cfg_data;
      endcase
    end
  end

  // Element store for A: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_value;
    end
    rd_a_r <= mem_a[{i_r, k_r}];
  end

  // Element store for B: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_value;
    end
    rd_b_r <= mem_b[{k_r, j_r}];
  end

  // Read and multiply stages with their position tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
    t1_r.i          <= i_r;
    t1_r.j          <= j_r;
    t1_r.first      <= (k_r == '0);
    t1_r.last_k     <= k_last;
    t1_r.final_elem <= i_last && j_last;
    t2_r            <= t1_r;
    prod_r          <= rd_a_r * rd_b_r;
  end

  // Sequencer: state, loop counters, accumulator and result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_accept && (in_operation == OP_COMPUTE)) begin
            if (dim_mismatch) begin
              out_valid_r     <= 1'b1;
              out_row_r       <= '0;
              out_col_r       <= '0;
              out_product_r   <= '0;
              out_last_r      <= 1'b1;
              out_dim_error_r <= 1'b1;
            end else begin
              state_r   <= S_RUN;
              ra_last_r <= dim_last(rows_a_r);
              ia_last_r <= dim_last(inner_a_r);
              cb_last_r <= dim_last(cols_b_r);
              i_r       <= '0;
              j_r       <= '0;
              k_r       <= '0;
            end
          end
        end
        S_RUN: begin
          if (k_last) begin
            k_r <= '0;
            if (j_last) begin
              j_r <= '0;
              if (i_last) begin
                i_r     <= '0;
                state_r <= S_DRAIN;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (v2_r && t2_r.last_k && t2_r.final_elem) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Accumulate each term and emit the element after its last term.
      if (v2_r) begin
        acc_r <= sum;
        if (t2_r.last_k) begin
          out_valid_r     <= 1'b1;
          out_row_r       <= POS_W'(t2_r.i);
          out_col_r       <= POS_W'(t2_r.j);
          out_product_r   <= sat_word(sum);
          out_last_r      <= t2_r.final_elem;
          out_dim_error_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_product   = out_product_r;
  assign out_last      = out_last_r;
  assign out_dim_error = out_dim_error_r;

  // A dimension error result is always the only and last beat of its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dim_error |-> out_last)
    else $error("dimension error beat without last");

  // A mismatched compute request answers with an error beat in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_accept && (in_operation == OP_COMPUTE) && dim_mismatch
      |=> out_valid && out_dim_error)
    else $error("missing dimension error beat");

  // The pipeline is empty whenever the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !v1_r && !v2_r)
    else $error("pipeline busy while sequencer idle");

  // The final beat of a run coincides with the block going idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("last beat while still busy");

endmodule

### test/matrix_multiply_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the matrix multiply unit: tracks the stores and dimensions and checks each result beat.
module matrix_multiply_unit_checker import mmu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [2:0]               in_row,
  input  logic [2:0]               in_col,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     out_valid,
  input  logic [POS_W-1:0]         out_row,
  input  logic [POS_W-1:0]         out_col,
  input  logic signed [DATA_W-1:0] out_product,
  input  logic                     out_last,
  input  logic                     out_dim_error,
  output int                       fail_total,
  output int                       due_count,
  output int                       beats_checked
);

  // One element of a product stream as it should appear on the result port.
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DATA_W-1:0] product;
    logic              last;
    logic              dim_error;
  } product_beat_t;

  // Mirror of the element stores and of the dimension registers.
  logic signed [DATA_W-1:0] a_cells [DEPTH];
  logic signed [DATA_W-1:0] b_cells [DEPTH];
  logic [DIM_W-1:0]         dim_reg [4];

  product_beat_t due_elements [$];
  int mismatch_count = 0;
  int waiting        = 0;
  int compared       = 0;

  assign fail_total    = mismatch_count;
  assign due_count     = waiting;
  assign beats_checked = compared;

  // A register of zero acts as one, anything above the store size as the store size.
  function automatic int dim_in_use(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Prints a single line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input product_beat_t beat);
    if (got !== want) begin
      report_mismatch($sformatf("%s of element (%0d,%0d): got %h, expected %h",
                                name, beat.row, beat.col, got, want));
    end
  endtask

  // Works out every beat of one compute request from the current stores and dimensions.
  task automatic predict_product_stream();
    int rows;
    int inner;
    int depth_b;
    int cols;
    logic signed [2*DATA_W-1:0] acc;
    logic signed [2*DATA_W-1:0] wa;
    logic signed [2*DATA_W-1:0] wb;
    product_beat_t beat;
    rows    = dim_in_use(dim_reg[CFG_ROWS_A]);
    inner   = dim_in_use(dim_reg[CFG_INNER_A]);
    depth_b = dim_in_use(dim_reg[CFG_ROWS_B]);
    cols    = dim_in_use(dim_reg[CFG_COLS_B]);
    // Inner dimensions that disagree give one flagged beat and no arithmetic.
    if (inner != depth_b) begin
      beat = '0;
      beat.last = 1'b1;
      beat.dim_error = 1'b1;
      due_elements.push_back(beat);
      return;
    end
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        acc = '0;
        // Each term is the exact product floored back to Q16.16.
        for (int k = 0; k < inner; k++) begin
          wa = a_cells[i * MAX_DIM + k];
          wb = b_cells[k * MAX_DIM + j];
          acc = acc + ((wa * wb) >>> FRAC_W);
        end
        beat = '0;
        beat.row = POS_W'(i);
        beat.col = POS_W'(j);
        if (acc > 64'sd2147483647) begin
          beat.product = 32'h7FFF_FFFF;
        end else if (acc < -64'sd2147483648) begin
          beat.product = 32'h8000_0000;
        end else begin
          beat.product = acc[DATA_W-1:0];
        end
        beat.last = (i == rows - 1) && (j == cols - 1);
        due_elements.push_back(beat);
      end
    end
  endtask

  // Result beats are checked before the edge's command is predicted, so order is kept.
  always @(posedge clk) begin
    product_beat_t want;
    if (!rst_n) begin
      due_elements.delete();
      for (int r = 0; r < 4; r++) dim_reg[r] = DIM_RESET;
    end else begin
      if (out_valid) begin
        if (due_elements.size() == 0) begin
          report_mismatch($sformatf("result beat at (%0d,%0d) with nothing expected",
                                    out_row, out_col));
        end else begin
          want = due_elements.pop_front();
          check_field("row", 32'(out_row), 32'(want.row), want);
          check_field("col", 32'(out_col), 32'(want.col), want);
          check_field("product", out_product, want.product, want);
          check_field("last", 32'(out_last), 32'(want.last), want);
          check_field("dim_error", 32'(out_dim_error), 32'(want.dim_error), want);
          compared++;
        end
      end
      if (cfg_valid && cfg_ready) dim_reg[cfg_index] = cfg_data;
      if (start && !busy) begin
        case (in_operation)
          OP_WRITE_A: a_cells[{in_row, in_col}] = in_value;
          OP_WRITE_B: b_cells[{in_row, in_col}] = in_value;
          OP_COMPUTE: predict_product_stream();
          default: ;
        endcase
      end
    end
    waiting = due_elements.size();
  end

endmodule

### test/matrix_multiply_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the matrix multiply unit: stimulus, watchdog and verdict.
module matrix_multiply_unit_tb;
  import mmu_pkg::*;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 380;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_operation;
  logic [2:0]               in_row;
  logic [2:0]               in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [DIM_W-1:0]         cfg_data;
  logic                     out_valid;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_product;
  logic                     out_last;
  logic                     out_dim_error;
  int                       fail_total;
  int                       due_count;
  int                       beats_checked;

  // Which store entries hold a value, so that no product reads an unwritten one.
  bit a_written [DEPTH];
  bit b_written [DEPTH];
  int burst_left    = 0;
  int command_count = 0;
  int run_count     = 0;
  int setting_count = 0;

  always #10 clk = ~clk;

  matrix_multiply_unit dut (.*);

  matrix_multiply_unit_checker product_check (.*);

  // Element values: mostly small numbers, some full range, some at the limits.
  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      4, 5, 6:    return $urandom();
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
  endfunction

  // Sizes are mostly small; the full size shows up now and then.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 7);
    return MAX_DIM;
  endfunction

  // Register value for a size, sometimes using the out-of-range encodings.
  function automatic logic [DIM_W-1:0] encode_dim(input int n);
    if (n == 1 && $urandom_range(0, 3) == 0) return '0;
    if (n == MAX_DIM && $urandom_range(0, 1) == 0) return DIM_W'($urandom_range(9, 15));
    return DIM_W'(n);
  endfunction

  // Sends one command beat; the sender pauses between bursts of random length.
  task automatic issue(input logic [1:0] op, input logic [2:0] row,
                       input logic [2:0] col, input logic [31:0] value);
    if (burst_left == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    start        = 1'b1;
    in_operation = op;
    in_row       = row;
    in_col       = col;
    in_value     = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE_A) a_written[{row, col}] = 1'b1;
    if (op == OP_WRITE_B) b_written[{row, col}] = 1'b1;
    if (op != OP_UNUSED) command_count++;
    if (op == OP_COMPUTE) run_count++;
  endtask

  // Fills any entry of the region a product will read that has not been written yet.
  task automatic load_missing(input int rows, input int inner, input int cols);
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < inner; k++) begin
        if (!a_written[i * MAX_DIM + k]) issue(OP_WRITE_A, 3'(i), 3'(k), random_q16());
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < cols; j++) begin
        if (!b_written[k * MAX_DIM + j]) issue(OP_WRITE_B, 3'(k), 3'(j), random_q16());
      end
    end
  endtask

  task automatic write_dim(input cfg_idx_t idx, input logic [DIM_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Lets the block go idle, then writes all four dimension registers.
  task automatic apply_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ia,
                            input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    @(negedge clk);
    start = 1'b0;
    burst_left = 0;
    while (due_count != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_dim(CFG_ROWS_A, ra);
    write_dim(CFG_INNER_A, ia);
    write_dim(CFG_ROWS_B, rb);
    write_dim(CFG_COLS_B, cb);
    @(negedge clk);
    cfg_valid = 1'b0;
    setting_count++;
  endtask

  // Ends the run when nothing has been accepted for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("matrix_multiply_unit_tb: done, errors");
    $finish;
  end

  initial begin
    int rows;
    int inner;
    int depth_b;
    int cols;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_WRITE_A;
    in_row       = '0;
    in_col       = '0;
    in_value     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROWS_A;
    cfg_data     = DIM_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // 2x2 by 2x2 with limit values: saturation and rounding toward minus infinity.
    apply_dims(4'd2, 4'd2, 4'd2, 4'd2);
    issue(OP_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    issue(OP_WRITE_A, 3'd0, 3'd1, 32'h8000_0000);
    issue(OP_WRITE_A, 3'd1, 3'd0, 32'h0001_0000);
    issue(OP_WRITE_A, 3'd1, 3'd1, 32'hFFFF_0000);
    issue(OP_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    issue(OP_WRITE_B, 3'd0, 3'd1, 32'h0001_8000);
    issue(OP_WRITE_B, 3'd1, 3'd0, 32'h8000_0000);
    issue(OP_WRITE_B, 3'd1, 3'd1, 32'hFFFF_FFFF);
    issue(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    issue(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    issue(OP_WRITE_B, 3'd7, 3'd7, 32'h0000_0001);

    // Inner dimensions disagree: a single flagged beat.
    apply_dims(4'd1, 4'd3, 4'd2, 4'd8);
    issue(OP_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);

    // Out-of-range registers: 15 acts as eight rows, zero acts as one.
    apply_dims(4'd15, 4'd1, 4'd0, 4'd1);
    load_missing(MAX_DIM, 1, 1);
    issue(OP_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);

    // Random settings, each with a few loads-then-compute sequences.
    while (command_count < ITEM_TARGET) begin
      rows    = pick_size();
      inner   = pick_size();
      cols    = pick_size();
      depth_b = ($urandom_range(0, 3) == 0) ? pick_size() : inner;
      apply_dims(encode_dim(rows), encode_dim(inner), encode_dim(depth_b), encode_dim(cols));
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 11) == 0) begin
            issue(OP_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
          end else begin
            issue($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                  3'($urandom()), 3'($urandom()), random_q16());
          end
        end
        if (inner == depth_b) load_missing(rows, inner, cols);
        issue(OP_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
      end
    end

    // Wait for the last product beats, then a little longer for strays.
    @(negedge clk);
    start = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("matrix_multiply_unit_tb: %0d commands, %0d of them product runs, %0d settings",
             command_count, run_count, setting_count);
    $display("matrix_multiply_unit_tb: %0d result beats compared, %0d mismatches",
             beats_checked, fail_total);
    if (fail_total == 0) begin
      $display("matrix_multiply_unit_tb: done, clean");
    end else begin
      $display("matrix_multiply_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
